// ===== design/fsms_pkg.sv =====
`timescale 1ns / 1ps
// Package for the floppy seek and motor sequencer: item types, state, codes.
package fsms_pkg;

	// Recalibrate gives up on the next outward step once this many have gone without track zero
	localparam logic [7:0] RECAL_STEP_LIMIT = 8'd80;

	// Operation codes of an input item
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_RECAL    = 3'd1;
	localparam logic [2:0] OP_SEEK     = 3'd2;
	localparam logic [2:0] OP_CHG_STEP = 3'd3;
	localparam logic [2:0] OP_PREP_IO  = 3'd4;
	localparam logic [2:0] OP_MOTOR_OFF = 3'd5;

	// Completion codes
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_OFFLINE   = 3'd1;
	localparam logic [2:0] ERR_TIMEOUT   = 3'd2;
	localparam logic [2:0] ERR_CHANGED   = 3'd3;
	localparam logic [2:0] ERR_MOTOR_OFF = 3'd4;
	localparam logic [2:0] ERR_BUSY      = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] CFG_MAX_CYL      = 3'd0;
	localparam logic [2:0] CFG_REVERSE_WAIT = 3'd1;
	localparam logic [2:0] CFG_SIDE_WAIT    = 3'd2;
	localparam logic [2:0] CFG_STEP         = 3'd3;
	localparam logic [2:0] CFG_SEEK_SETTLE  = 3'd4;
	localparam logic [2:0] CFG_HEAD_SETTLE  = 3'd5;
	localparam logic [2:0] CFG_SPINUP       = 3'd6;
	localparam logic [2:0] CFG_MOTOR_OFF    = 3'd7;

	typedef enum logic [1:0] {
		MOTOR_OFF    = 2'd0,
		MOTOR_SPINUP = 2'd1,
		MOTOR_ON     = 2'd2
	} fsms_motor_t;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_RECAL_STEP  = 3'd1,
		PH_RECAL_SETTLE = 3'd2,
		PH_SEEK_STEP   = 3'd3,
		PH_SEEK_SETTLE = 3'd4,
		PH_IO_STEP     = 3'd5,
		PH_IO_SETTLE   = 3'd6,
		PH_IO_READY    = 3'd7
	} fsms_phase_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] target_cylinder;
		logic       target_head;
		logic       at_track_zero;
		logic       disk_ready;
		logic       disk_changed;
	} fsms_in_t;

	typedef struct packed {
		logic       motor_enable;
		logic       step_pulse;
		logic       step_inward;
		logic       head_select;
		logic       busy_res;
		logic       done_res;
		logic [2:0] error_code;
		logic [7:0] current_cylinder;
		logic       online;
	} fsms_out_t;

	typedef struct packed {
		logic [7:0]  max_cylinder;
		logic [15:0] reverse_wait_ticks;
		logic [15:0] side_wait_ticks;
		logic [15:0] step_ticks;
		logic [15:0] seek_settle_ticks;
		logic [15:0] head_settle_ticks;
		logic [15:0] spinup_timeout_ticks;
		logic [19:0] motor_off_ticks;
	} fsms_cfg_t;

	typedef struct packed {
		logic [7:0]  head_cylinder;
		logic        current_head;
		logic        last_seek_inward;
		logic        reset_step_inward;
		fsms_motor_t motor_phase;
		logic        drive_online;
		fsms_phase_t sequence_phase;
		logic [15:0] wait_counter;
		logic [7:0]  steps_left;
		logic        goal_head;
		logic [19:0] off_counter;
	} fsms_state_t;

endpackage

// ===== design/fsms_step.sv =====
`timescale 1ns / 1ps
// Next-state and result logic for one tick or command of the sequencer.
module fsms_step (
	input  fsms_pkg::fsms_state_t st,
	input  fsms_pkg::fsms_cfg_t   cfg,
	input  fsms_pkg::fsms_in_t    item,
	output fsms_pkg::fsms_state_t nxt,
	output fsms_pkg::fsms_out_t   res
);
	import fsms_pkg::*;

	// Set up a seek: direction, step count and pre-wait.
	function automatic fsms_state_t start_seek(input fsms_state_t s, input logic [7:0] cyl,
			input logic head, input logic io, input fsms_cfg_t c);
		fsms_state_t r;
		logic        inward;
		logic [7:0]  n;
		logic [15:0] pre;
		r = s;
		inward = (cyl >= s.head_cylinder);
		n = inward ? (cyl - s.head_cylinder) : (s.head_cylinder - cyl);
		pre = 16'd0;
		if (n != 8'd0 && inward != s.last_seek_inward)
			pre = c.reverse_wait_ticks;
		if (c.side_wait_ticks > pre)
			pre = c.side_wait_ticks;
		if (n != 8'd0)
			r.last_seek_inward = inward;
		r.steps_left = n;
		r.goal_head = head;
		r.wait_counter = pre;
		r.sequence_phase = io ? PH_IO_STEP : PH_SEEK_STEP;
		return r;
	endfunction

	always_comb begin
		logic             r_step;
		logic             r_inward;
		logic             r_done;
		logic [2:0]       r_err;
		logic [7:0]       clamped;
		logic signed [9:0] cyl_s;
		logic signed [9:0] c_s;
		logic signed [9:0] max_s;
		logic             rsi;
		logic [7:0]       c_cyl;
		logic [7:0]       left;

		nxt = st;
		r_step = 1'b0;
		r_inward = 1'b0;
		r_done = 1'b0;
		r_err = ERR_OK;
		clamped = (item.target_cylinder > cfg.max_cylinder) ? cfg.max_cylinder
			: item.target_cylinder;
		cyl_s = signed'({2'b00, st.head_cylinder});
		max_s = signed'({2'b00, cfg.max_cylinder});
		c_s = '0;
		rsi = st.reset_step_inward;
		c_cyl = '0;
		left = '0;

		case (item.op)
			OP_TICK: begin
				// auto-off timer first
				if (nxt.motor_phase != MOTOR_OFF) begin
					if (nxt.off_counter <= 20'd1) begin
						nxt.motor_phase = MOTOR_OFF;
						nxt.off_counter = '0;
					end else begin
						nxt.off_counter = nxt.off_counter - 20'd1;
					end
				end
				if (nxt.sequence_phase == PH_IO_READY) begin
					if (nxt.motor_phase == MOTOR_OFF) begin
						r_done = 1'b1;
						r_err = ERR_MOTOR_OFF;
						nxt.sequence_phase = PH_IDLE;
						nxt.wait_counter = '0;
					end else if (item.disk_changed) begin
						r_done = 1'b1;
						r_err = ERR_CHANGED;
						nxt.sequence_phase = PH_IDLE;
						nxt.wait_counter = '0;
					end else if (item.disk_ready) begin
						nxt.motor_phase = MOTOR_ON;
						r_done = 1'b1;
						nxt.sequence_phase = PH_IDLE;
						nxt.wait_counter = '0;
					end else if (nxt.wait_counter <= 16'd1) begin
						nxt.motor_phase = MOTOR_OFF;
						nxt.off_counter = '0;
						r_done = 1'b1;
						r_err = ERR_TIMEOUT;
						nxt.sequence_phase = PH_IDLE;
						nxt.wait_counter = '0;
					end else begin
						nxt.wait_counter = nxt.wait_counter - 16'd1;
					end
				end else if (nxt.sequence_phase != PH_IDLE) begin
					if (nxt.wait_counter != 16'd0)
						nxt.wait_counter = nxt.wait_counter - 16'd1;
					if (nxt.wait_counter == 16'd0) begin
						case (nxt.sequence_phase)
							PH_RECAL_STEP: begin
								if (item.at_track_zero) begin
									nxt.current_head = 1'b0;
									nxt.wait_counter = cfg.seek_settle_ticks;
									nxt.sequence_phase = PH_RECAL_SETTLE;
								end else begin
									r_step = 1'b1;
									if (nxt.head_cylinder != 8'd0)
										nxt.head_cylinder = nxt.head_cylinder - 8'd1;
									if (nxt.steps_left >= RECAL_STEP_LIMIT) begin
										nxt.drive_online = 1'b0;
										nxt.motor_phase = MOTOR_OFF;
										nxt.off_counter = '0;
										r_done = 1'b1;
										r_err = ERR_TIMEOUT;
										nxt.sequence_phase = PH_IDLE;
										nxt.wait_counter = '0;
									end else begin
										nxt.steps_left = nxt.steps_left + 8'd1;
										nxt.wait_counter = cfg.step_ticks;
									end
								end
							end
							PH_RECAL_SETTLE: begin
								nxt.head_cylinder = '0;
								nxt.current_head = 1'b0;
								nxt.last_seek_inward = 1'b0;
								nxt.drive_online = 1'b1;
								r_done = 1'b1;
								nxt.sequence_phase = PH_IDLE;
								nxt.wait_counter = '0;
							end
							PH_SEEK_STEP, PH_IO_STEP: begin
								if (nxt.steps_left != 8'd0) begin
									r_step = 1'b1;
									r_inward = nxt.last_seek_inward;
									nxt.head_cylinder = nxt.last_seek_inward
										? nxt.head_cylinder + 8'd1 : nxt.head_cylinder - 8'd1;
									left = nxt.steps_left - 8'd1;
									nxt.steps_left = left;
									if (left != 8'd0) begin
										nxt.wait_counter = cfg.step_ticks;
									end else begin
										nxt.current_head = nxt.goal_head;
										nxt.wait_counter = cfg.seek_settle_ticks;
										nxt.sequence_phase =
											(st.sequence_phase == PH_IO_STEP)
											? PH_IO_SETTLE : PH_SEEK_SETTLE;
									end
								end else begin
									nxt.wait_counter = (nxt.goal_head != nxt.current_head)
										? cfg.head_settle_ticks : 16'd0;
									nxt.current_head = nxt.goal_head;
									nxt.sequence_phase = (st.sequence_phase == PH_IO_STEP)
										? PH_IO_SETTLE : PH_SEEK_SETTLE;
								end
							end
							PH_IO_SETTLE: begin
								if (nxt.motor_phase == MOTOR_SPINUP) begin
									nxt.sequence_phase = PH_IO_READY;
									nxt.wait_counter = cfg.spinup_timeout_ticks;
								end else begin
									r_done = 1'b1;
									r_err = (nxt.motor_phase == MOTOR_OFF) ? ERR_MOTOR_OFF
										: ERR_OK;
									nxt.sequence_phase = PH_IDLE;
									nxt.wait_counter = '0;
								end
							end
							default: begin
								r_done = 1'b1;
								nxt.sequence_phase = PH_IDLE;
								nxt.wait_counter = '0;
							end
						endcase
					end
				end
			end
			OP_MOTOR_OFF: begin
				nxt.motor_phase = MOTOR_OFF;
				nxt.off_counter = '0;
				r_done = 1'b1;
			end
			OP_RECAL, OP_SEEK, OP_CHG_STEP, OP_PREP_IO: begin
				if (st.sequence_phase != PH_IDLE) begin
					r_done = 1'b1;
					r_err = ERR_BUSY;
				end else if (item.op == OP_RECAL) begin
					nxt.steps_left = '0;
					nxt.wait_counter = cfg.reverse_wait_ticks;
					nxt.sequence_phase = PH_RECAL_STEP;
				end else if (!st.drive_online) begin
					r_done = 1'b1;
					r_err = ERR_OFFLINE;
					nxt.wait_counter = '0;
				end else if (item.op == OP_SEEK) begin
					nxt = start_seek(st, clamped, item.target_head, 1'b0, cfg);
				end else if (item.op == OP_CHG_STEP) begin
					// nudge one cylinder, alternating direction, kept in range
					c_s = st.reset_step_inward ? (cyl_s + 10'sd1) : (cyl_s - 10'sd1);
					if (c_s > max_s) begin
						c_s = cyl_s - 10'sd1;
						rsi = 1'b0;
					end else if (c_s < 10'sd0) begin
						c_s = 10'sd1;
						rsi = 1'b1;
					end
					if (c_s < 10'sd0)
						c_s = 10'sd0;
					if (c_s > max_s)
						c_s = max_s;
					c_cyl = c_s[7:0];
					nxt = start_seek(st, c_cyl, st.current_head, 1'b0, cfg);
					nxt.reset_step_inward = ~rsi;
				end else begin
					nxt.off_counter = cfg.motor_off_ticks;
					if (st.motor_phase == MOTOR_OFF)
						nxt.motor_phase = MOTOR_SPINUP;
					if (clamped != st.head_cylinder || item.target_head != st.current_head) begin
						nxt = start_seek(nxt, clamped, item.target_head, 1'b1, cfg);
					end else if (nxt.motor_phase == MOTOR_SPINUP) begin
						nxt.sequence_phase = PH_IO_READY;
						nxt.wait_counter = cfg.spinup_timeout_ticks;
					end else begin
						r_done = 1'b1;
						r_err = ERR_OK;
						nxt.wait_counter = '0;
					end
				end
			end
			default: begin
			end
		endcase

		res.motor_enable = (nxt.motor_phase != MOTOR_OFF);
		res.step_pulse = r_step;
		res.step_inward = r_inward;
		res.head_select = nxt.current_head;
		res.busy_res = (nxt.sequence_phase != PH_IDLE);
		res.done_res = r_done;
		res.error_code = r_err;
		res.current_cylinder = nxt.head_cylinder;
		res.online = nxt.drive_online;
	end

endmodule

// ===== design/floppy_seek_motor_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the floppy seek and motor sequencer.
//
// Usage notes:
//  - Input channel (in_valid / in_stall / in_data): one item per transfer, either a
//    time tick or a command, always carrying the sampled drive status lines.
//  - Output channel (out_valid / out_stall / out_data): exactly one result per
//    accepted item, in order: motor, step pulse and direction, head, busy,
//    done with completion code, believed cylinder and online flag.
//  - Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready
//    is always high; write only while the block is idle.
//  - Each accepted item is held in the input register, and its result in the result
//    register until the output transfer takes it.
//  - Throughput: one item per cycle while the output is not stalled, set by the single
//    next-state pass between input and result registers; all timers are counted in ticks.
//  - A stall on the output holds the result register; the input register then fills
//    and in_stall rises in the same cycle, so nothing is lost or repeated.
//  - Reset: sequence idle, motor off, drive offline, head at cylinder zero, and the
//    registers return to their default timings.
module floppy_seek_motor_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fsms_pkg::fsms_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output fsms_pkg::fsms_out_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [19:0]          cfg_data
);
	import fsms_pkg::*;

	fsms_in_t    item_s1;
	logic        valid_s1;
	fsms_out_t   res_s2;
	logic        valid_s2;
	fsms_state_t state_q;
	fsms_cfg_t   cfg_q;
	fsms_state_t state_nxt;
	fsms_out_t   res_nxt;
	logic        advance;

	// item in the input register moves on when the result register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;
	assign cfg_ready = 1'b1;

	fsms_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// control: pipeline valids and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= '{
				head_cylinder:     8'd0,
				current_head:      1'b0,
				last_seek_inward:  1'b0,
				reset_step_inward: 1'b0,
				motor_phase:       MOTOR_OFF,
				drive_online:      1'b0,
				sequence_phase:    PH_IDLE,
				wait_counter:      16'd0,
				steps_left:        8'd0,
				goal_head:         1'b0,
				off_counter:       20'd0
			};
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
		if (advance)
			res_s2 <= res_nxt;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				max_cylinder:         8'd79,
				reverse_wait_ticks:   16'd180,
				side_wait_ticks:      16'd20,
				step_ticks:           16'd30,
				seek_settle_ticks:    16'd160,
				head_settle_ticks:    16'd1,
				spinup_timeout_ticks: 16'd5000,
				motor_off_ticks:      20'd40000
			};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_CYL:      cfg_q.max_cylinder <= cfg_data[7:0];
				CFG_REVERSE_WAIT: cfg_q.reverse_wait_ticks <= cfg_data[15:0];
				CFG_SIDE_WAIT:    cfg_q.side_wait_ticks <= cfg_data[15:0];
				CFG_STEP:         cfg_q.step_ticks <= cfg_data[15:0];
				CFG_SEEK_SETTLE:  cfg_q.seek_settle_ticks <= cfg_data[15:0];
				CFG_HEAD_SETTLE:  cfg_q.head_settle_ticks <= cfg_data[15:0];
				CFG_SPINUP:       cfg_q.spinup_timeout_ticks <= cfg_data[15:0];
				CFG_MOTOR_OFF:    cfg_q.motor_off_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the floppy seek and motor sequencer, directed rows then random streams.
module tb;
	import fsms_pkg::*;

	// op codes the block must ignore; the package gives them no name
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT = 3000;
	// length of the deliberate output hold-off
	localparam int HOLD_CYCLES = 60;
	localparam int REPORT_MAX = 10;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	fsms_in_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	fsms_out_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	floppy_seek_motor_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------------
	// Drive status predictor: its own copy of the timings and sequencer state.
	// Only a tick moves time; a command either starts a sequence or completes at once.
	// ---------------------------------------------------------------------------
	fsms_cfg_t   timing;
	logic [7:0]  head_cyl;
	logic        head_side;
	logic        last_inward;
	logic        chg_inward;   // direction of the next disk-change reset step
	fsms_motor_t motor;
	logic        online_st;
	fsms_phase_t phase;
	logic [15:0] wait_cnt;
	logic [7:0]  steps;
	logic        goal_side;
	logic [19:0] off_cnt;
	// per-item result bits
	logic        r_step, r_inward, r_done;
	logic [2:0]  r_err;

	fsms_out_t status_due[$];   // predicted status words not yet seen at the output

	function automatic void seq_finish(logic [2:0] err);
		r_done   = 1'b1;
		r_err    = err;
		phase    = PH_IDLE;
		wait_cnt = '0;
	endfunction

	function automatic void motor_stop();
		motor   = MOTOR_OFF;
		off_cnt = '0;
	endfunction

	// end of a prepare-io: done if at speed, fail if stopped, else poll for ready
	function automatic void ready_check();
		if (motor == MOTOR_ON)
			seq_finish(ERR_OK);
		else if (motor == MOTOR_OFF)
			seq_finish(ERR_MOTOR_OFF);
		else begin
			phase    = PH_IO_READY;
			wait_cnt = timing.spinup_timeout_ticks;
		end
	endfunction

	// pre-wait is the side wait, or the longer of it and the reversal wait when the direction flips
	function automatic void seek_begin(logic [7:0] cyl, logic side, bit io);
		bit          inward;
		logic [7:0]  span;
		logic [15:0] pre;
		inward = (cyl >= head_cyl);
		span   = inward ? cyl - head_cyl : head_cyl - cyl;
		pre    = '0;
		if (span != 0 && inward != last_inward)
			pre = timing.reverse_wait_ticks;
		if (timing.side_wait_ticks > pre)
			pre = timing.side_wait_ticks;
		if (span != 0)
			last_inward = inward;
		steps     = span;
		goal_side = side;
		wait_cnt  = pre;
		phase     = io ? PH_IO_STEP : PH_SEEK_STEP;
	endfunction

	function automatic void step_due(bit io);
		bit change;
		change = (goal_side != head_side);
		if (steps != 0) begin
			r_step   = 1'b1;
			r_inward = last_inward;
			head_cyl = last_inward ? head_cyl + 8'd1 : head_cyl - 8'd1;
			steps--;
			if (steps != 0) begin
				wait_cnt = timing.step_ticks;
				return;
			end
			head_side = goal_side;
			wait_cnt  = timing.seek_settle_ticks;
		end else begin
			head_side = goal_side;
			wait_cnt  = change ? timing.head_settle_ticks : 16'd0;
		end
		phase = io ? PH_IO_SETTLE : PH_SEEK_SETTLE;
	endfunction

	function automatic fsms_out_t next_status(fsms_in_t it);
		fsms_out_t  o;
		logic [7:0] cyl;
		int         nc;
		r_step   = 1'b0;
		r_inward = 1'b0;
		r_done   = 1'b0;
		r_err    = ERR_OK;
		case (it.op)
			OP_TICK: begin
				// auto-off runs before the sequence on every tick
				if (motor != MOTOR_OFF) begin
					if (off_cnt <= 20'd1)
						motor_stop();
					else
						off_cnt--;
				end
				if (phase == PH_IO_READY) begin
					if (motor == MOTOR_OFF)
						seq_finish(ERR_MOTOR_OFF);
					else if (it.disk_changed)
						seq_finish(ERR_CHANGED);
					else if (it.disk_ready) begin
						motor = MOTOR_ON;
						seq_finish(ERR_OK);
					end else if (wait_cnt <= 16'd1) begin
						motor_stop();
						seq_finish(ERR_TIMEOUT);
					end else
						wait_cnt--;
				end else if (phase != PH_IDLE) begin
					if (wait_cnt != 0)
						wait_cnt--;
					if (wait_cnt == 0) begin
						case (phase)
							PH_RECAL_STEP: begin
								if (it.at_track_zero) begin
									head_side = 1'b0;
									wait_cnt  = timing.seek_settle_ticks;
									phase     = PH_RECAL_SETTLE;
								end else begin
									r_step = 1'b1;
									if (head_cyl != 0)
										head_cyl--;
									if (steps >= RECAL_STEP_LIMIT) begin
										online_st = 1'b0;
										motor_stop();
										seq_finish(ERR_TIMEOUT);
									end else begin
										steps++;
										wait_cnt = timing.step_ticks;
									end
								end
							end
							PH_RECAL_SETTLE: begin
								head_cyl    = '0;
								head_side   = 1'b0;
								last_inward = 1'b0;
								online_st   = 1'b1;
								seq_finish(ERR_OK);
							end
							PH_SEEK_STEP: step_due(1'b0);
							PH_IO_STEP:   step_due(1'b1);
							PH_IO_SETTLE: ready_check();
							default:      seq_finish(ERR_OK);
						endcase
					end
				end
			end
			OP_MOTOR_OFF: begin
				motor_stop();
				r_done = 1'b1;
			end
			OP_RECAL, OP_SEEK, OP_CHG_STEP, OP_PREP_IO: begin
				if (phase != PH_IDLE) begin
					r_done = 1'b1;
					r_err  = ERR_BUSY;
				end else if (it.op == OP_RECAL) begin
					steps    = '0;
					wait_cnt = timing.reverse_wait_ticks;
					phase    = PH_RECAL_STEP;
				end else if (!online_st)
					seq_finish(ERR_OFFLINE);
				else if (it.op == OP_SEEK) begin
					cyl = (it.target_cylinder > timing.max_cylinder) ?
						timing.max_cylinder : it.target_cylinder;
					seek_begin(cyl, it.target_head, 1'b0);
				end else if (it.op == OP_CHG_STEP) begin
					// one step back or forth, bounced off both ends of the disk
					nc = chg_inward ? int'(head_cyl) + 1 : int'(head_cyl) - 1;
					if (nc > int'(timing.max_cylinder)) begin
						nc = int'(head_cyl) - 1;
						chg_inward = 1'b0;
					end else if (nc < 0) begin
						nc = 1;
						chg_inward = 1'b1;
					end
					if (nc < 0)
						nc = 0;
					if (nc > int'(timing.max_cylinder))
						nc = int'(timing.max_cylinder);
					chg_inward = ~chg_inward;
					seek_begin(8'(nc), head_side, 1'b0);
				end else begin
					cyl = (it.target_cylinder > timing.max_cylinder) ?
						timing.max_cylinder : it.target_cylinder;
					if (motor == MOTOR_OFF)
						motor = MOTOR_SPINUP;
					off_cnt = timing.motor_off_ticks;
					if (cyl != head_cyl || it.target_head != head_side)
						seek_begin(cyl, it.target_head, 1'b1);
					else
						ready_check();
				end
			end
			default: ;   // spare codes: no state change, no time
		endcase
		o                  = '0;
		o.motor_enable     = (motor != MOTOR_OFF);
		o.step_pulse       = r_step;
		o.step_inward      = r_inward;
		o.head_select      = head_side;
		o.busy_res         = (phase != PH_IDLE);
		o.done_res         = r_done;
		o.error_code       = r_err;
		o.current_cylinder = head_cyl;
		o.online           = online_st;
		return o;
	endfunction

	// ---------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------
	int idle_pct   = 0;   // chance per transfer/cycle of an idle burst, both sides
	int hold_asked = 0;   // bumped to ask the receiver for one long hold-off
	int items_sent = 0;
	int reg_writes = 0;
	int settings   = 0;
	int completions = 0;
	int err_count  = 0;
	int busy_count = 0;
	int pulses     = 0;

	function automatic fsms_in_t mk(logic [2:0] op, logic [7:0] tc, logic th,
			logic tz, logic rdy, logic chg);
		fsms_in_t it;
		it.op              = op;
		it.target_cylinder = tc;
		it.target_head     = th;
		it.at_track_zero   = tz;
		it.disk_ready      = rdy;
		it.disk_changed    = chg;
		return it;
	endfunction

	// status word with everything quiet except busy, done and the code
	function automatic fsms_out_t plain(logic busy, logic done, logic [2:0] err);
		fsms_out_t o;
		o            = '0;
		o.busy_res   = busy;
		o.done_res   = done;
		o.error_code = err;
		return o;
	endfunction

	// predict, queue the expectation (typed one if given), then offer the transfer
	task automatic issue(fsms_in_t it, bit typed, fsms_out_t want);
		fsms_out_t guess;
		int        gap;
		guess = next_status(it);
		status_due.push_back(typed ? want : guess);
		if (guess.done_res) begin
			completions++;
			if (guess.error_code != ERR_OK)
				err_count++;
			if (guess.error_code == ERR_BUSY)
				busy_count++;
		end
		if (guess.step_pulse)
			pulses++;
		gap = (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) ?
			$urandom_range(1, 15) : 0;
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// sender stops offering until every predicted status word has come back
	task automatic pause_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);   // two-stage pipeline plus margin
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	task automatic apply_timing(fsms_cfg_t c);
		write_reg(CFG_MAX_CYL,      {12'd0, c.max_cylinder});
		write_reg(CFG_REVERSE_WAIT, {4'd0, c.reverse_wait_ticks});
		write_reg(CFG_SIDE_WAIT,    {4'd0, c.side_wait_ticks});
		write_reg(CFG_STEP,         {4'd0, c.step_ticks});
		write_reg(CFG_SEEK_SETTLE,  {4'd0, c.seek_settle_ticks});
		write_reg(CFG_HEAD_SETTLE,  {4'd0, c.head_settle_ticks});
		write_reg(CFG_SPINUP,       {4'd0, c.spinup_timeout_ticks});
		write_reg(CFG_MOTOR_OFF,    c.motor_off_ticks);
		timing = c;
		settings++;
	endtask

	// Random item, shaped by the predicted state: mostly ticks, commands when idle,
	// a few commands while busy and a few spare codes as noise.
	// slow: only commands that finish without long waits (huge timer settings).
	function automatic fsms_in_t pick_item(int tz_pct, bit slow);
		fsms_in_t it;
		int       r;
		int       sel;
		it.op              = OP_TICK;
		it.target_cylinder = ($urandom_range(0, 9) < 7) ?
			8'($urandom_range(0, timing.max_cylinder)) : 8'($urandom);
		it.target_head     = 1'($urandom_range(0, 1));
		it.at_track_zero   = (phase == PH_RECAL_STEP) ?
			($urandom_range(0, 99) < tz_pct) : 1'($urandom_range(0, 1));
		it.disk_ready      = $urandom_range(0, 99) < (slow ? 50 : 35);
		it.disk_changed    = $urandom_range(0, 99) < 10;
		r = $urandom_range(0, 99);
		if (r < 3)
			it.op = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
		else if (phase != PH_IDLE) begin
			if (r < 9)
				it.op = 3'($urandom_range(OP_RECAL, OP_MOTOR_OFF));
		end else if (r < 35) begin
			sel = $urandom_range(0, 9);
			if (slow) begin
				it.op              = (sel < 7) ? OP_PREP_IO : OP_MOTOR_OFF;
				it.target_cylinder = head_cyl;
				it.target_head     = head_side;
			end else if (!online_st && sel < 6)
				it.op = OP_RECAL;
			else
				case (sel)
					0:       it.op = OP_RECAL;
					1, 2, 3: it.op = OP_SEEK;
					4, 5:    it.op = OP_CHG_STEP;
					6, 7, 8: it.op = OP_PREP_IO;
					default: it.op = OP_MOTOR_OFF;
				endcase
		end
		return it;
	endfunction

	// One setting: finish whatever sequence is running, go idle, reprogram, then stream.
	task automatic run_phase(fsms_cfg_t c, int count, int tz_pct, bit slow,
			bit pressure, int idle);
		while (phase != PH_IDLE)
			issue(mk(OP_TICK, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0), 1'b0, '0);
		pause_for_results();
		apply_timing(c);
		idle_pct = idle;
		for (int k = 0; k < count; k++) begin
			if (pressure && k == 40)
				hold_asked++;            // sink holds off while we keep offering
			if (pressure && k == 100)
				pause_for_results();     // source waits for the pipeline to empty
			issue(pick_item(tz_pct, slow), 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------------------
	// Directed table: spare codes, offline rejects, busy reject, recalibrate, a seek past the
	// last cylinder, disk change and motor off during the ready wait, and a change-reset step.
	// ---------------------------------------------------------------------------
	fsms_in_t  dir_in[$];
	bit        dir_typed[$];
	fsms_out_t dir_want[$];

	function automatic void row(fsms_in_t it, bit typed, fsms_out_t want);
		dir_in.push_back(it);
		dir_typed.push_back(typed);
		dir_want.push_back(want);
	endfunction

	// ---------------------------------------------------------------------------
	// Result sink: random stall bursts plus the one long hold-off on request
	// ---------------------------------------------------------------------------
	initial begin
		int burst;
		int hold;
		int hold_served;
		burst = 0;
		hold = 0;
		hold_served = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				burst = $urandom_range(1, 15) - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------------
	// Checker: every output transfer against the oldest prediction
	// ---------------------------------------------------------------------------
	int faults = 0;

	function automatic string show(fsms_out_t s);
		return $sformatf("mot=%b stp=%b in=%b hd=%b busy=%b done=%b err=%0d cyl=%0d onl=%b",
			s.motor_enable, s.step_pulse, s.step_inward, s.head_select, s.busy_res,
			s.done_res, s.error_code, s.current_cylinder, s.online);
	endfunction

	always @(posedge clk) begin
		fsms_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_MAX)
					$display("%0t: status transfer with nothing predicted: %s",
						$realtime, show(out_data));
			end else begin
				want = status_due.pop_front();
				if (out_data !== want) begin
					faults++;
					if (faults <= REPORT_MAX) begin
						$display("%0t: status mismatch", $realtime);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(out_data));
					end
				end
			end
		end
	end

	// Watchdog: too long without any transfer on any channel means a hang
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results outstanding",
			STALL_LIMIT, status_due.size());
		$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------
	initial begin
		fsms_cfg_t quick, low_end, wide, mid, high_end, closing;
		// power-on timings and state
		timing      = {8'd79, 16'd180, 16'd20, 16'd30, 16'd160, 16'd1, 16'd5000, 20'd40000};
		head_cyl    = '0;
		head_side   = 1'b0;
		last_inward = 1'b0;
		chg_inward  = 1'b0;
		motor       = MOTOR_OFF;
		online_st   = 1'b0;
		phase       = PH_IDLE;
		wait_cnt    = '0;
		steps       = '0;
		goal_side   = 1'b0;
		off_cnt     = '0;

		// field order: max_cyl, reverse, side, step, seek settle, head settle,
		// spin-up, motor off
		quick    = {8'd3,   16'd2,     16'd1,     16'd1,     16'd1,     16'd1,
			16'd2,     20'd12};
		low_end  = {8'd1,   16'd0,     16'd0,     16'd1,     16'd0,     16'd0,
			16'd0,     20'd0};        // zero timers act as a single tick
		wide     = {8'd255, 16'd3,     16'd1,     16'd1,     16'd2,     16'd1,
			16'd4,     20'd300};
		mid      = {8'd40,  16'd5,     16'd2,     16'd2,     16'd3,     16'd2,
			16'd6,     20'd60};
		high_end = {8'd255, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
			16'd65535, 20'd1000000};
		closing  = {8'd79,  16'd4,     16'd2,     16'd1,     16'd4,     16'd1,
			16'd5000,  20'd40000};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows; timings kept tiny so each sequence ends in a few ticks
		row(mk(OP_UNUSED_LO, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1, plain(1'b0, 1'b0, ERR_OK));
		row(mk(OP_UNUSED_HI, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1), 1'b1, plain(1'b0, 1'b0, ERR_OK));
		row(mk(OP_SEEK, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1), 1'b1, plain(1'b0, 1'b1, ERR_OFFLINE));
		row(mk(OP_CHG_STEP, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1, plain(1'b0, 1'b1, ERR_OFFLINE));
		row(mk(OP_PREP_IO, 8'd3, 1'b1, 1'b0, 1'b1, 1'b0), 1'b1, plain(1'b0, 1'b1, ERR_OFFLINE));
		row(mk(OP_MOTOR_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1, plain(1'b0, 1'b1, ERR_OK));
		row(mk(OP_RECAL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		// any command while a sequence runs is turned away
		row(mk(OP_SEEK, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1, plain(1'b1, 1'b1, ERR_BUSY));
		// reversal wait, one outward step, track zero, settle, online
		row(mk(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		row(mk(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		row(mk(OP_TICK, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b0, '0);
		row(mk(OP_TICK, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b0, '0);
		// target past the last cylinder saturates; head changes with the last step
		row(mk(OP_SEEK, 8'd255, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		repeat (5) row(mk(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		// ready wait broken by a disk change
		row(mk(OP_PREP_IO, 8'd3, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		row(mk(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0, '0);
		// ready wait broken by a motor off command
		row(mk(OP_PREP_IO, 8'd3, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		row(mk(OP_MOTOR_OFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		row(mk(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		// change-reset step from the innermost cylinder
		row(mk(OP_CHG_STEP, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0);
		repeat (4) row(mk(OP_TICK, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0), 1'b0, '0);

		apply_timing(quick);
		idle_pct = 10;
		foreach (dir_in[i])
			issue(dir_in[i], dir_typed[i], dir_want[i]);

		// random part over several timing settings, extremes included
		run_phase(low_end,  90,  30, 1'b0, 1'b0, 15);
		run_phase(wide,     60,  0,  1'b0, 1'b0, 10);   // track zero never seen
		run_phase(mid,      150, 25, 1'b0, 1'b1, 5);
		run_phase(high_end, 40,  50, 1'b1, 1'b0, 10);
		run_phase(closing,  150, 40, 1'b0, 1'b0, 0);    // no idling to the end

		pause_for_results();
		repeat (8) @(posedge clk);
		$display("%0d items over %0d timing settings (%0d register writes), %0d step pulses",
			items_sent, settings, reg_writes, pulses);
		$display("%0d completions, %0d with an error code, %0d of them busy rejects",
			completions, err_count, busy_count);
		if (faults == 0 && status_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
